FILE: src/bnf_pkg.sv
// Shared types, constants and codes for the batch normalization forward block.
`timescale 1ns / 1ps

package bnf_pkg;

  localparam int unsigned DATA_BITS       = 16;
  localparam int unsigned CHANNELS_DEF    = 64;
  localparam int unsigned CH_BITS         = 6;
  localparam int unsigned FUNC_BITS       = 2;
  localparam int unsigned CNT_BITS        = 24;
  localparam int unsigned EPS_BITS        = 16;
  localparam int unsigned CFG_IDX_BITS    = 1;
  localparam int unsigned CFG_DATA_BITS   = 24;
  localparam int unsigned SUM_BITS        = 40;
  localparam int unsigned SQ_BITS         = 56;
  localparam int unsigned SQR_BITS        = 2 * DATA_BITS;
  localparam int unsigned SCALE_BITS      = 32;
  localparam int unsigned DIV_NUM_BITS    = 56;
  localparam int unsigned DIV_DEN_BITS    = 32;
  localparam int unsigned RAD_BITS        = 58;
  localparam int unsigned ROOT_BITS       = RAD_BITS / 2;
  localparam int unsigned IN_QUEUE_DEPTH  = 4;
  localparam int unsigned OUT_QUEUE_DEPTH = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_ACC  = 2'd1,
    FUNC_NORM = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COUNT = 1'b0,
    CFG_EPS   = 1'b1
  } cfg_idx_e;

  // Work that the back end carries out for one queued item.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ACC,
    OP_NORM,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic                        last;
    logic [CH_BITS-1:0]          channel;
    logic signed [DATA_BITS-1:0] sample;
    logic signed [DATA_BITS-1:0] gain;
    logic signed [DATA_BITS-1:0] bias;
  } item_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic [EPS_BITS-1:0] eps;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] normalized;
    logic [CH_BITS-1:0]          channel;
    logic                        saturated;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACC_WR,
    ST_NRM_DIFF,
    ST_NRM_MUL,
    ST_NRM_OUT,
    ST_FIN_RD,
    ST_FIN_LAT,
    ST_FIN_MEAN_GO,
    ST_FIN_MEAN,
    ST_FIN_MSQ_GO,
    ST_FIN_MSQ,
    ST_FIN_VAR,
    ST_FIN_SQRT_GO,
    ST_FIN_SQRT,
    ST_FIN_SCL_GO,
    ST_FIN_SCL,
    ST_FIN_WR
  } st_e;

endpackage

FILE: src/bnf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bnf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bnf_fifo.sv
// Small register queue used on both sides of the back end.
`timescale 1ns / 1ps

module bnf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/bnf_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bnf_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [bnf_pkg::DIV_NUM_BITS-1:0] num_i,
  input  logic [bnf_pkg::DIV_DEN_BITS-1:0] den_i,
  output logic                             busy_o,
  output logic [bnf_pkg::DIV_NUM_BITS-1:0] quo_o
);

  import bnf_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NUM_BITS + 1);

  logic                    busy_q;
  logic [CW-1:0]           cnt_q;
  logic [DIV_DEN_BITS-1:0] rem_q, den_q;
  logic [DIV_NUM_BITS-1:0] quo_q;
  logic [DIV_DEN_BITS:0]   rem_sh, rem_sub;
  logic                    ge;

  assign rem_sh  = {rem_q, quo_q[DIV_NUM_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DIV_NUM_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DIV_DEN_BITS-1:0] : rem_sh[DIV_DEN_BITS-1:0];
      quo_q <= {quo_q[DIV_NUM_BITS-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

FILE: src/bnf_sqrt.sv
// Iterative integer square root, one root bit per cycle.
`timescale 1ns / 1ps

module bnf_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bnf_pkg::RAD_BITS-1:0]  rad_i,
  output logic                          busy_o,
  output logic [bnf_pkg::ROOT_BITS-1:0] root_o
);

  import bnf_pkg::*;

  localparam int unsigned CW = $clog2(ROOT_BITS + 1);
  localparam int unsigned RW = ROOT_BITS + 2;

  logic                 busy_q;
  logic [CW-1:0]        cnt_q;
  logic [RAD_BITS-1:0]  x_q;
  logic [RW-1:0]        rem_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [RW+1:0]        rem_sh, trial, rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, x_q[RAD_BITS-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign ge      = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(ROOT_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[RAD_BITS-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
      root_q <= {root_q[ROOT_BITS-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

FILE: src/bnf_front.sv
// Front end: accepts items, drops those with no effect, and queues the rest.
`timescale 1ns / 1ps

module bnf_front #(
  parameter int unsigned CHANNELS = bnf_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [bnf_pkg::FUNC_BITS-1:0]       func_i,
  input  logic [bnf_pkg::CH_BITS-1:0]         channel_i,
  input  logic signed [bnf_pkg::DATA_BITS-1:0] sample_i,
  input  logic signed [bnf_pkg::DATA_BITS-1:0] gain_i,
  input  logic signed [bnf_pkg::DATA_BITS-1:0] bias_i,
  input  logic                                last_i,
  input  logic                                q_pop_i,
  output logic                                q_empty_o,
  output bnf_pkg::item_t                      q_item_o
);

  import bnf_pkg::*;

  logic  ch_ok, keep;
  op_e   op;
  item_t item;
  logic [$bits(item_t)-1:0] q_rdata;

  assign ch_ok = (32'(channel_i) < CHANNELS);

  always_comb begin
    keep = 1'b0;
    op   = OP_LOAD;
    case (func_i)
      FUNC_LOAD: begin
        keep = ch_ok;
        op   = OP_LOAD;
      end
      FUNC_ACC: begin
        // An out-of-range accumulate still finalizes when it is the last one.
        keep = ch_ok || last_i;
        op   = ch_ok ? OP_ACC : OP_FIN;
      end
      FUNC_NORM: begin
        keep = ch_ok;
        op   = OP_NORM;
      end
      default: begin
        keep = 1'b0;
        op   = OP_LOAD;
      end
    endcase
  end

  always_comb begin
    item.op      = op;
    item.last    = last_i;
    item.channel = channel_i;
    item.sample  = sample_i;
    item.gain    = gain_i;
    item.bias    = bias_i;
  end

  bnf_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (IN_QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .wdata_i (item),
    .pop_i   (q_pop_i),
    .rdata_o (q_rdata),
    .full_o  (full_o),
    .empty_o (q_empty_o)
  );

  assign q_item_o = item_t'(q_rdata);

endmodule

FILE: src/bnf_back.sv
// Back end: per-channel storage, accumulation, finalize sequencing and normalize math.
`timescale 1ns / 1ps

module bnf_back #(
  parameter int unsigned CHANNELS = bnf_pkg::CHANNELS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bnf_pkg::cfg_t   cfg_i,
  input  logic            q_empty_i,
  input  bnf_pkg::item_t  q_item_i,
  output logic            q_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output bnf_pkg::res_t   res_o
);

  import bnf_pkg::*;

  localparam int unsigned CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SUMS_W  = SUM_BITS + SQ_BITS;
  localparam int unsigned GB_W    = 2 * DATA_BITS;
  localparam int unsigned MS_W    = DATA_BITS + SCALE_BITS;
  localparam int unsigned DIFF_W  = DATA_BITS + 1;
  localparam int unsigned PROD_W  = SCALE_BITS + DIFF_W;
  localparam int unsigned RES_W   = PROD_W + 1 - 16 + 1;
  localparam logic signed [RES_W-1:0] R_MAX = (RES_W'(1) <<< (DATA_BITS - 1)) - RES_W'(1);
  localparam logic signed [RES_W-1:0] R_MIN = -R_MAX - RES_W'(1);
  localparam logic [DIV_NUM_BITS-1:0] MEAN_POS = DIV_NUM_BITS'(R_MAX);
  localparam logic [DIV_NUM_BITS-1:0] MEAN_NEG = DIV_NUM_BITS'(R_MAX) + 1'b1;

  st_e state_q, state_d;

  item_t                     it_q;
  logic [CH_AW-1:0]          fin_c_q, fin_c_d;
  logic [CHANNELS-1:0]       vld_q;
  logic [CH_AW-1:0]          q_ch, it_ch;

  logic [SQR_BITS-1:0]       sqr_q;
  logic signed [SUM_BITS-1:0] fsum_q;
  logic [SQ_BITS-1:0]        fsq_q;
  logic signed [DATA_BITS-1:0] fgain_q, mean_q;
  logic [DIV_NUM_BITS-1:0]   msq_q;
  logic [SQR_BITS-1:0]       mm_q;
  logic [RAD_BITS-1:0]       rad_q;
  logic signed [SCALE_BITS-1:0] scale_q, nscale_q;
  logic signed [DATA_BITS-1:0] nbias_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [PROD_W-1:0]  prod_q;

  // Memory ports.
  logic              sums_we, sums_re, gb_we, gb_re, ms_we, ms_re;
  logic [CH_AW-1:0]  sums_waddr, sums_raddr, gb_raddr;
  logic [SUMS_W-1:0] sums_wdata, sums_rdata;
  logic [GB_W-1:0]   gb_rdata;
  logic [MS_W-1:0]   ms_rdata;

  // Arithmetic units: a divider shared by the finalize steps, and a square root.
  logic                    div_start, div_busy, sqrt_start, sqrt_busy;
  logic [DIV_NUM_BITS-1:0] div_num, div_quo;
  logic [DIV_DEN_BITS-1:0] div_den, count_n;
  logic [ROOT_BITS-1:0]    root;

  logic [SUM_BITS-1:0]     old_sum, sum_mag;
  logic [SQ_BITS-1:0]      old_sq;
  logic                    row_vld;
  logic [DATA_BITS-1:0]    gain_mag;
  logic [RAD_BITS-1:0]     var_raw;
  logic signed [PROD_W:0]  rnd;
  logic signed [RES_W-1:0] res_wide;

  assign q_ch  = CH_AW'(q_item_i.channel);
  assign it_ch = CH_AW'(it_q.channel);
  assign count_n = (cfg_i.count == '0) ? DIV_DEN_BITS'(1) : DIV_DEN_BITS'(cfg_i.count);

  // Sums rows that were never written since reset or finalize read as zero.
  assign row_vld = (state_q == ST_ACC_WR) ? vld_q[it_ch] : vld_q[fin_c_q];
  assign old_sum = row_vld ? sums_rdata[SUMS_W-1 -: SUM_BITS] : '0;
  assign old_sq  = row_vld ? sums_rdata[SQ_BITS-1:0] : '0;

  assign sum_mag  = fsum_q[SUM_BITS-1] ? SUM_BITS'(-fsum_q) : SUM_BITS'(fsum_q);
  assign gain_mag = fgain_q[DATA_BITS-1] ? DATA_BITS'(-fgain_q) : DATA_BITS'(fgain_q);
  assign var_raw  = RAD_BITS'(msq_q) - RAD_BITS'(mm_q) + RAD_BITS'(cfg_i.eps);

  // Round half up to Q8.8, then add the bias.
  assign rnd      = PROD_W'(prod_q) + (PROD_W + 1)'(32768);
  assign res_wide = RES_W'($signed(rnd[PROD_W:16])) + RES_W'(nbias_q);

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    fin_c_d = fin_c_q;
    case (state_q)
      ST_IDLE: begin
        fin_c_d = '0;
        if (!q_empty_i) begin
          case (q_item_i.op)
            OP_ACC:  state_d = ST_ACC_WR;
            OP_NORM: state_d = ST_NRM_DIFF;
            OP_FIN:  state_d = ST_FIN_RD;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC_WR:      state_d = it_q.last ? ST_FIN_RD : ST_IDLE;
      ST_NRM_DIFF:    state_d = ST_NRM_MUL;
      ST_NRM_MUL:     state_d = ST_NRM_OUT;
      ST_NRM_OUT:     state_d = res_full_i ? ST_NRM_OUT : ST_IDLE;
      ST_FIN_RD:      state_d = ST_FIN_LAT;
      ST_FIN_LAT:     state_d = ST_FIN_MEAN_GO;
      ST_FIN_MEAN_GO: state_d = ST_FIN_MEAN;
      ST_FIN_MEAN:    state_d = div_busy ? ST_FIN_MEAN : ST_FIN_MSQ_GO;
      ST_FIN_MSQ_GO:  state_d = ST_FIN_MSQ;
      ST_FIN_MSQ:     state_d = div_busy ? ST_FIN_MSQ : ST_FIN_VAR;
      ST_FIN_VAR:     state_d = ST_FIN_SQRT_GO;
      ST_FIN_SQRT_GO: state_d = ST_FIN_SQRT;
      ST_FIN_SQRT: begin
        if (!sqrt_busy) begin
          state_d = (root == '0) ? ST_FIN_WR : ST_FIN_SCL_GO;
        end
      end
      ST_FIN_SCL_GO:  state_d = ST_FIN_SCL;
      ST_FIN_SCL:     state_d = div_busy ? ST_FIN_SCL : ST_FIN_WR;
      ST_FIN_WR: begin
        if (fin_c_q == CH_AW'(CHANNELS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          fin_c_d = fin_c_q + 1'b1;
          state_d = ST_FIN_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    q_pop_o    = 1'b0;
    sums_re    = 1'b0;
    sums_raddr = q_ch;
    sums_we    = 1'b0;
    sums_waddr = it_ch;
    sums_wdata = {old_sum + SUM_BITS'(it_q.sample), old_sq + SQ_BITS'(sqr_q)};
    gb_we      = 1'b0;
    gb_re      = 1'b0;
    gb_raddr   = q_ch;
    ms_re      = 1'b0;
    ms_we      = 1'b0;
    div_start  = 1'b0;
    div_num    = DIV_NUM_BITS'(sum_mag);
    div_den    = count_n;
    sqrt_start = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          gb_we   = (q_item_i.op == OP_LOAD);
          sums_re = (q_item_i.op == OP_ACC);
          gb_re   = (q_item_i.op == OP_NORM);
          ms_re   = (q_item_i.op == OP_NORM);
        end
      end
      ST_ACC_WR:  sums_we = 1'b1;
      ST_NRM_OUT: res_push_o = !res_full_i;
      ST_FIN_RD: begin
        sums_re    = 1'b1;
        sums_raddr = fin_c_q;
        gb_re      = 1'b1;
        gb_raddr   = fin_c_q;
      end
      ST_FIN_MEAN_GO: div_start = 1'b1;
      ST_FIN_MSQ_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_BITS'(fsq_q);
      end
      ST_FIN_SQRT_GO: sqrt_start = 1'b1;
      ST_FIN_SCL_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_BITS'({gain_mag, 16'h0000});
        div_den   = DIV_DEN_BITS'(root);
      end
      ST_FIN_WR: ms_we = 1'b1;
      default: ;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_c_q <= '0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      fin_c_q <= fin_c_d;
      if (state_q == ST_ACC_WR) begin
        vld_q[it_ch] <= 1'b1;
      end
      if (state_q == ST_FIN_WR) begin
        vld_q[fin_c_q] <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        it_q  <= q_item_i;
        sqr_q <= SQR_BITS'(q_item_i.sample * q_item_i.sample);
      end
      ST_NRM_DIFF: begin
        nscale_q <= ms_rdata[SCALE_BITS-1:0];
        nbias_q  <= gb_rdata[DATA_BITS-1:0];
        diff_q   <= DIFF_W'(it_q.sample) - DIFF_W'($signed(ms_rdata[MS_W-1 -: DATA_BITS]));
      end
      ST_NRM_MUL: prod_q <= nscale_q * diff_q;
      ST_FIN_LAT: begin
        fsum_q  <= old_sum;
        fsq_q   <= old_sq;
        fgain_q <= gb_rdata[GB_W-1 -: DATA_BITS];
      end
      ST_FIN_MEAN: begin
        // Truncated mean, saturated to the sample range.
        if (fsum_q[SUM_BITS-1]) begin
          mean_q <= (div_quo > MEAN_NEG) ? DATA_BITS'(R_MIN) : DATA_BITS'(-div_quo);
        end else begin
          mean_q <= (div_quo > MEAN_POS) ? DATA_BITS'(R_MAX) : DATA_BITS'(div_quo);
        end
      end
      ST_FIN_MSQ: begin
        msq_q <= div_quo;
        mm_q  <= SQR_BITS'(mean_q * mean_q);
      end
      ST_FIN_VAR: rad_q <= var_raw[RAD_BITS-1] ? '0 : var_raw;
      ST_FIN_SQRT: begin
        // A zero sigma gives the extreme scale of the gain's sign.
        if (fgain_q > 0) begin
          scale_q <= {1'b0, {(SCALE_BITS-1){1'b1}}};
        end else if (fgain_q < 0) begin
          scale_q <= {1'b1, {(SCALE_BITS-1){1'b0}}};
        end else begin
          scale_q <= '0;
        end
      end
      ST_FIN_SCL: begin
        scale_q <= fgain_q[DATA_BITS-1] ? -div_quo[SCALE_BITS-1:0] : div_quo[SCALE_BITS-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.channel = it_q.channel;
    if (res_wide > R_MAX) begin
      res_o.normalized = DATA_BITS'(R_MAX);
      res_o.saturated  = 1'b1;
    end else if (res_wide < R_MIN) begin
      res_o.normalized = DATA_BITS'(R_MIN);
      res_o.saturated  = 1'b1;
    end else begin
      res_o.normalized = DATA_BITS'(res_wide);
      res_o.saturated  = 1'b0;
    end
  end

  // ---------------- storage and units ----------------
  bnf_ram #(.WIDTH(SUMS_W), .DEPTH(CHANNELS)) u_sums (
    .clk_i   (clk_i),
    .we_i    (sums_we),
    .waddr_i (sums_waddr),
    .wdata_i (sums_wdata),
    .re_i    (sums_re),
    .raddr_i (sums_raddr),
    .rdata_o (sums_rdata)
  );

  bnf_ram #(.WIDTH(GB_W), .DEPTH(CHANNELS)) u_gain_bias (
    .clk_i   (clk_i),
    .we_i    (gb_we),
    .waddr_i (q_ch),
    .wdata_i ({q_item_i.gain, q_item_i.bias}),
    .re_i    (gb_re),
    .raddr_i (gb_raddr),
    .rdata_o (gb_rdata)
  );

  bnf_ram #(.WIDTH(MS_W), .DEPTH(CHANNELS)) u_mean_scale (
    .clk_i   (clk_i),
    .we_i    (ms_we),
    .waddr_i (fin_c_q),
    .wdata_i ({mean_q, scale_q}),
    .re_i    (ms_re),
    .raddr_i (q_ch),
    .rdata_o (ms_rdata)
  );

  bnf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  bnf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

endmodule

FILE: src/batch_norm_forward.sv
// Top level of the per-channel batch normalization forward block.
//
//   channel  direction  handshake                fields
//   input    in         push_i / full_o          func, channel, sample, gain, bias, last
//   result   out        pop_i / empty_o          normalized, out_channel, saturated
//   config   in         cfg_we_i (no wait)       cfg_idx_i selects count or epsilon
//
// Items pass through a four-entry input queue into a sequencer that handles one
// item at a time: a load writes gain and bias, an accumulate reads and writes
// back the sums, and a normalize waits on a full result queue. A last accumulate
// finalizes every channel, paced by the shared one-bit-per-cycle divider (up to
// three 56-step divisions) and the 29-step square root.
// Reset clears the sums through per-channel valid bits, so no clearing pass runs.
// The two-entry result queue lets the input side keep taking items while a
// result waits to be popped.
`timescale 1ns / 1ps

module batch_norm_forward #(
  parameter int unsigned CHANNELS = bnf_pkg::CHANNELS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input items.
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic [bnf_pkg::FUNC_BITS-1:0]        func_i,
  input  logic [bnf_pkg::CH_BITS-1:0]          channel_i,
  input  logic signed [bnf_pkg::DATA_BITS-1:0] sample_i,
  input  logic signed [bnf_pkg::DATA_BITS-1:0] gain_i,
  input  logic signed [bnf_pkg::DATA_BITS-1:0] bias_i,
  input  logic                                 last_i,
  // Result items.
  output logic                                 empty_o,
  input  logic                                 pop_i,
  output logic signed [bnf_pkg::DATA_BITS-1:0] normalized_o,
  output logic [bnf_pkg::CH_BITS-1:0]          out_channel_o,
  output logic                                 saturated_o,
  // Configuration writes.
  input  logic                                 cfg_we_i,
  input  logic [bnf_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [bnf_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);

  import bnf_pkg::*;

  cfg_t  cfg_q;
  item_t q_item;
  res_t  res_in, res_out;
  logic  q_pop, q_empty, res_push, res_full;
  logic [$bits(res_t)-1:0] res_rdata;

  // Config registers; the user must write only while the block is idle (unchecked).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count <= CNT_BITS'(1);
      cfg_q.eps   <= EPS_BITS'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_COUNT) begin
        cfg_q.count <= cfg_data_i[CNT_BITS-1:0];
      end
      if (cfg_idx_i == CFG_EPS) begin
        cfg_q.eps <= cfg_data_i[EPS_BITS-1:0];
      end
    end
  end

  bnf_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .func_i    (func_i),
    .channel_i (channel_i),
    .sample_i  (sample_i),
    .gain_i    (gain_i),
    .bias_i    (bias_i),
    .last_i    (last_i),
    .q_pop_i   (q_pop),
    .q_empty_o (q_empty),
    .q_item_o  (q_item)
  );

  bnf_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Result queue that decouples the sequencer from the consumer.
  bnf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop_i),
    .rdata_o (res_rdata),
    .full_o  (res_full),
    .empty_o (empty_o)
  );

  assign res_out       = res_t'(res_rdata);
  assign normalized_o  = res_out.normalized;
  assign out_channel_o = res_out.channel;
  assign saturated_o   = res_out.saturated;

`ifndef SYNTHESIS
  // The sequencer never pushes a result into a full result queue.
  a_no_res_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result pushed into full queue");

  // The sequencer only takes items that the input queue holds.
  a_no_q_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("item popped from empty queue");

  // A saturated result sits at one of the two range limits.
  a_sat_at_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && saturated_o) |->
      (normalized_o == 16'sh7fff || normalized_o == 16'sh8000))
    else $error("saturated flag on an in-range value");
`endif

endmodule
